FILE: src/crws_pkg.sv
// Shared types, constants and cipher parameters for the random word stream core.
`default_nettype none

package crws_pkg;

  // Number of cipher rounds per block.
  localparam int ROUNDS = 10;
  localparam int RoundW = $clog2(ROUNDS);

  // Round multipliers and key schedule increments.
  localparam logic [31:0] PhxM0 = 32'hD251_1F53;
  localparam logic [31:0] PhxM1 = 32'hCD9E_8D57;
  localparam logic [31:0] PhxW0 = 32'h9E37_79B9;
  localparam logic [31:0] PhxW1 = 32'hBB67_AE85;

  // Highest word position inside a block.
  localparam logic [1:0] LastPos = 2'd3;

  // Command queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_INDEX    = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STREAM_ID_ONE   = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_STREAM_ID_TWO   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_STREAM_ID_THREE = 8'd3;

  typedef enum logic [0:0] {
    OP_PICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [31:0] seq;
    logic [1:0]  pos;
  } cmd_t;

  // Configuration words seen by the round engine.
  typedef struct packed {
    logic [31:0] global_index;
    logic [31:0] stream_id_one;
    logic [31:0] stream_id_two;
    logic [31:0] stream_id_three;
  } cfg_t;

  // Start request from the back to the round engine.
  typedef struct packed {
    logic        start;
    logic [31:0] ctr0;
  } rnd_start_t;

  typedef logic [3:0][31:0] block_t;

endpackage

`default_nettype wire

FILE: src/crws_front.sv
// Front end: accepts input transfers, decodes them and queues commands.
`default_nettype none

module crws_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [39:0]    s_axis_tdata,
  input  wire logic [0:0]     s_axis_tuser,
  output crws_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  wire logic           cmd_ready
);
  import crws_pkg::*;

  cmd_t            q [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            push;
  logic            pop;
  cmd_t            new_cmd;
  logic [7:0]      sel;

  assign s_axis_tready = (count != CntW'(QueueDepth));
  assign cmd_valid     = (count != '0);
  assign cmd           = q[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid && cmd_ready;

  // A word position above the last one falls back to the first word.
  always_comb begin
    sel         = s_axis_tdata[39:32];
    new_cmd.op  = op_e'(s_axis_tuser);
    new_cmd.seq = s_axis_tdata[31:0];
    new_cmd.pos = (sel[7:2] != '0) ? 2'd0 : sel[1:0];
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + CntW'(1);
      2'b01:   count_next = count - CntW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth))
    else $error("command queue count exceeds its depth");
`endif

endmodule

`default_nettype wire

FILE: src/crws_round.sv
// Round engine: one cipher round per cycle; its state holds the finished block.
`default_nettype none

module crws_round (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire crws_pkg::rnd_start_t go,
  input  wire crws_pkg::cfg_t       cfg,
  output logic                      busy,
  output crws_pkg::block_t          block
);
  import crws_pkg::*;

  logic [31:0]       x [4];
  logic [31:0]       k0;
  logic [31:0]       k1;
  logic [RoundW-1:0] rnd;
  logic [63:0]       p0;
  logic [63:0]       p1;

  assign p0 = 64'(PhxM0) * 64'(x[0]);
  assign p1 = 64'(PhxM1) * 64'(x[2]);

  assign block[0] = x[0];
  assign block[1] = x[1];
  assign block[2] = x[2];
  assign block[3] = x[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go.start) begin
      busy <= 1'b1;
    end else if (busy && (rnd == RoundW'(ROUNDS - 1))) begin
      busy <= 1'b0;
    end
  end

  // The key and counter words are captured at start, so later register
  // writes do not disturb a block in progress.
  always_ff @(posedge clk) begin
    if (go.start) begin
      x[0] <= go.ctr0;
      x[1] <= cfg.stream_id_three;
      x[2] <= cfg.stream_id_one;
      x[3] <= cfg.stream_id_two;
      k0   <= cfg.global_index;
      k1   <= '0;
      rnd  <= '0;
    end else if (busy) begin
      x[0] <= p1[63:32] ^ x[1] ^ k0;
      x[1] <= p1[31:0];
      x[2] <= p0[63:32] ^ x[3] ^ k1;
      x[3] <= p0[31:0];
      k0   <= k0 + PhxW0;
      k1   <= k1 + PhxW1;
      rnd  <= rnd + RoundW'(1);
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    go.start |=> busy)
    else $error("round engine not busy after start");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    go.start |-> ##(ROUNDS + 1) !busy)
    else $error("round engine did not finish after the expected round count");
`endif

endmodule

`default_nettype wire

FILE: src/crws_back.sv
// Back end: executes commands, keeps sequence and position, drives the result.
`default_nettype none

module crws_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire crws_pkg::cmd_t   cmd,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire logic             eng_busy,
  input  wire crws_pkg::block_t block,
  output crws_pkg::rnd_start_t  go,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [71:0]           m_axis_tdata
);
  import crws_pkg::*;

  logic [31:0] seq;
  logic [31:0] seq_next;
  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic [31:0] word;
  logic        pop;
  logic [31:0] out_word;
  logic [31:0] out_seq;
  logic [1:0]  out_pos;

  assign cmd_ready = !eng_busy && (!m_axis_tvalid || m_axis_tready);
  assign pop       = cmd_valid && cmd_ready;
  assign m_axis_tdata = {6'b0, out_pos, out_seq, out_word};

  always_comb begin
    seq_next = seq;
    pos_next = pos;
    word     = '0;
    go.start = 1'b0;
    if (pop) begin
      case (cmd.op)
        OP_SET: begin
          seq_next = cmd.seq;
          pos_next = cmd.pos;
          go.start = 1'b1;
        end
        OP_PICK: begin
          word = block[pos];
          if (pos == LastPos) begin
            // Block used up: move to the next sequence word and recompute.
            pos_next = '0;
            seq_next = seq + 32'd1;
            go.start = 1'b1;
          end else begin
            pos_next = pos + 2'd1;
          end
        end
        default: ;
      endcase
    end
    go.ctr0 = seq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= '0;
      pos           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      seq <= seq_next;
      pos <= pos_next;
      if (pop) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= word;
      out_seq  <= seq_next;
      out_pos  <= pos_next;
    end
  end

`ifndef SYNTHESIS
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    pop && (cmd.op == OP_PICK) && (pos == LastPos)
    |=> (pos == 2'd0) && (seq == $past(seq) + 32'd1))
    else $error("wrap did not reset position and advance sequence");
  a_set_start: assert property (@(posedge clk) disable iff (rst)
    pop && (cmd.op == OP_SET) |-> go.start && (go.ctr0 == cmd.seq))
    else $error("set command did not start a block with its sequence word");
`endif

endmodule

`default_nettype wire

FILE: src/counter_based_random_word_stream_core.sv
// Top level of the counter-based random word stream core.
// Path: each command passes the queue and then the result register, where its result is
// offered. Flow: a pick inside a block is taken while the round engine is idle and the
// result register is free or being read; a set or a pick of the last word starts the round
// engine (one round a cycle), and the back end takes no further command until the engine
// is done. Reset (rst, synchronous): sequence, position, registers and queue clear.
`default_nettype none

module counter_based_random_word_stream_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [31:0] seq_value, [39:32] word_select
  input  wire logic [0:0]  s_axis_tuser,  // [0] operation
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata   // [31:0] random_word, [63:32] seq_out,
                                          // [65:64] position_out, [71:66] zero
);
  import crws_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_ready;
  logic       eng_busy;
  block_t     block;
  rnd_start_t go;

  // Configuration registers accept a write in every cycle. The round engine
  // captures them when a block starts, so a write only affects the next block.
  // Indexes beyond the register list are accepted and ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GLOBAL_INDEX:    cfg.global_index    <= cfg_data;
        CFG_STREAM_ID_ONE:   cfg.stream_id_one   <= cfg_data;
        CFG_STREAM_ID_TWO:   cfg.stream_id_two   <= cfg_data;
        CFG_STREAM_ID_THREE: cfg.stream_id_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front decodes each transfer into a command and queues it, so up to two
  // input transfers are taken while the back end waits on the round engine.
  crws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready)
  );

  // The back end owns the sequence word and position and the result register.
  crws_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .eng_busy      (eng_busy),
    .block         (block),
    .go            (go),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The round engine's state words are the block that picks read from.
  crws_round u_round (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .cfg   (cfg),
    .busy  (eng_busy),
    .block (block)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the counter-based random word stream core.
`timescale 1ns / 100ps

module testbench;
  import crws_pkg::*;

  // Cipher constants of the Philox4x32 round function, kept apart from the design.
  localparam int          PHILOX_ROUNDS = 10;
  localparam logic [31:0] MUL_A         = 32'hD251_1F53;
  localparam logic [31:0] MUL_B         = 32'hCD9E_8D57;
  localparam logic [31:0] WEYL_A        = 32'h9E37_79B9;
  localparam logic [31:0] WEYL_B        = 32'hBB67_AE85;
  localparam logic [1:0]  LAST_WORD     = 2'd3;

  // Cycles to let the round engine finish a background block before a register write.
  localparam int ENGINE_SETTLE = 20;
  localparam int TAIL_CYCLES   = 30;
  localparam int IDLE_LIMIT    = 2000;

  typedef logic [3:0][31:0] cipher_block_t;

  // One output transfer, split into its fields.
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] seq;
    logic [1:0]  pos;
  } draw_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index     = '0;
  logic [31:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  counter_based_random_word_stream_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: configuration copy and stream position.
  logic [31:0]   key_word;
  logic [31:0]   stream_one;
  logic [31:0]   stream_two;
  logic [31:0]   stream_three;
  logic [31:0]   cur_seq;
  logic [1:0]    cur_pos;
  cipher_block_t cur_block;

  draw_t pending_draws[$];
  int    error_count = 0;
  int    burst_left  = 0;
  int    idle_cycles = 0;

  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_left = 0;

  // Ten rounds of Philox4x32 over the counter {ctr0, id three, id one, id two}.
  function automatic cipher_block_t philox_block(input logic [31:0] ctr0);
    logic [31:0] x0, x1, x2, x3, k0, k1;
    logic [63:0] p0, p1;
    x0 = ctr0;
    x1 = stream_three;
    x2 = stream_one;
    x3 = stream_two;
    k0 = key_word;
    k1 = '0;
    for (int r = 0; r < PHILOX_ROUNDS; r++) begin
      if (r > 0) begin
        k0 = k0 + WEYL_A;
        k1 = k1 + WEYL_B;
      end
      p0 = {32'd0, MUL_A} * {32'd0, x0};
      p1 = {32'd0, MUL_B} * {32'd0, x2};
      x0 = p1[63:32] ^ x1 ^ k0;
      x1 = p1[31:0];
      x2 = p0[63:32] ^ x3 ^ k1;
      x3 = p0[31:0];
    end
    return {x3, x2, x1, x0};
  endfunction

  // Advances the stream by one command and returns the draw it must produce.
  function automatic draw_t advance_stream(input op_e op, input logic [31:0] seqv,
                                           input logic [7:0] sel);
    draw_t d;
    d.word = '0;
    if (op == OP_SET) begin
      cur_pos   = (sel > 8'(LAST_WORD)) ? 2'd0 : sel[1:0];
      cur_seq   = seqv;
      cur_block = philox_block(cur_seq);
    end else begin
      d.word = cur_block[cur_pos];
      if (cur_pos == LAST_WORD) begin
        cur_pos   = 2'd0;
        cur_seq   = cur_seq + 32'd1;
        cur_block = philox_block(cur_seq);
      end else begin
        cur_pos = cur_pos + 2'd1;
      end
    end
    d.seq = cur_seq;
    d.pos = cur_pos;
    return d;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  // Sends one command. The sender works in bursts; between most bursts it drops tvalid.
  task automatic send_item(input op_e op, input logic [31:0] seqv, input logic [7:0] sel);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sel, seqv};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_draws.push_back(advance_stream(op, seqv, sel));
    burst_left--;
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GLOBAL_INDEX:    key_word     = data;
      CFG_STREAM_ID_ONE:   stream_one   = data;
      CFG_STREAM_ID_TWO:   stream_two   = data;
      CFG_STREAM_ID_THREE: stream_three = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] gi, input logic [31:0] s1,
                              input logic [31:0] s2, input logic [31:0] s3);
    write_reg(CFG_STREAM_ID_THREE, s3);
    write_reg(CFG_GLOBAL_INDEX, gi);
    write_reg(CFG_STREAM_ID_TWO, s2);
    write_reg(CFG_STREAM_ID_ONE, s1);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender until every expected draw is out and the engine is quiet.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (ENGINE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Reset register values: zero key and zero stream ids.
  task automatic test_reset_config();
    send_item(OP_SET, 32'h0000_0000, 8'd0);
    repeat (5) send_item(OP_PICK, '0, '0);
  endtask

  // Field extremes and out-of-range positions, with every register at all ones.
  task automatic test_extremes();
    drain_results();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_SET, 32'hFFFF_FFFF, 8'd3);
    send_item(OP_PICK, 32'hFFFF_FFFF, 8'hFF);  // last word: sequence wraps to zero
    send_item(OP_PICK, '0, '0);
    send_item(OP_SET, 32'h8000_0000, 8'd4);
    send_item(OP_SET, 32'h0000_0001, 8'hFF);
    send_item(OP_SET, 32'h0000_0002, 8'h80);
    send_item(OP_SET, 32'h0000_0003, 8'd2);
    send_item(OP_PICK, '0, '0);
    send_item(OP_PICK, '0, '0);
    send_item(OP_SET, 32'h7FFF_FFFF, 8'd1);
    repeat (3) send_item(OP_PICK, '0, '0);
  endtask

  // A register write leaves the held block alone; the next wrap uses the new value.
  task automatic test_config_holds_block();
    drain_results();
    program_regs(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_item(OP_SET, 32'hCAFE_0001, 8'd1);
    send_item(OP_PICK, '0, '0);
    drain_results();
    program_regs(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004);
    repeat (4) send_item(OP_PICK, '0, '0);
  endtask

  // Several register settings, each followed by a set and two blocks' worth of picks.
  task automatic test_config_sweep();
    for (int s = 0; s < 4; s++) begin
      drain_results();
      case (s)
        0:       program_regs('0, '0, '0, '0);
        1:       program_regs(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        2:       program_regs(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        default: program_regs($urandom, $urandom, $urandom, $urandom);
      endcase
      send_item(OP_SET, $urandom, 8'($urandom_range(0, 3)));
      repeat (8) send_item(OP_PICK, $urandom, 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly picks with occasional sets; the registers change every so often.
  task automatic test_random_stream(input int count);
    op_e         op;
    logic [31:0] seqv;
    logic [7:0]  sel;
    for (int i = 0; i < count; i++) begin
      if (i % 110 == 109) begin
        drain_results();
        program_regs(pick_word(), pick_word(), pick_word(), pick_word());
      end
      op   = ($urandom_range(0, 99) < 15) ? OP_SET : OP_PICK;
      seqv = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : $urandom;
      sel  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
      send_item(op, seqv, sel);
    end
  endtask

  // Result side: the stall pattern switches between random modes.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(30, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= rx_left[2];
    endcase
  end

  // Compares every result transfer with the oldest expected draw.
  always @(posedge clk) begin
    draw_t exp_d;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_draws.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        exp_d = pending_draws.pop_front();
        check_field("random_word", exp_d.word, m_axis_tdata[31:0]);
        check_field("seq_out", exp_d.seq, m_axis_tdata[63:32]);
        check_field("position_out", 32'(exp_d.pos), 32'(m_axis_tdata[65:64]));
        check_field("pad bits", 32'd0, 32'(m_axis_tdata[71:66]));
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("counter_based_random_word_stream_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    key_word     = '0;
    stream_one   = '0;
    stream_two   = '0;
    stream_three = '0;
    cur_seq      = '0;
    cur_pos      = '0;
    cur_block    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_extremes();
    test_config_holds_block();
    test_config_sweep();
    test_random_stream(480);

    s_axis_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_draws.size() == 0) begin
      $display("counter_based_random_word_stream_core regression: pass");
    end else begin
      $display("counter_based_random_word_stream_core regression: fail");
    end
    $finish;
  end

endmodule
